// File: rtl/sfc_pkg.sv
`timescale 1ns / 1ps

package sfc_pkg;

    localparam int DEF_FRAC_BITS = 16;
    localparam int DEF_WORD_BITS = 32;

    localparam int LANES = 4;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_NEAR     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FAR      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOTTOM   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TOP      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INV_SIDE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_INV_VERT = 3'd7;

    // 1/sqrt(2) in Q2.30, rounded
    localparam longint INV_SQRT2_Q30 = 64'd759250125;

    localparam int FAR_RESET_UNITS = 100;

endpackage

// File: rtl/sphere_frustum_cull.sv
`timescale 1ns / 1ps

// Sphere vs. perspective frustum visibility test.
// Input: one transaction per cycle, taken when start is high and busy is low.
//   busy is always low: the datapath is a five-stage pipeline that takes a
//   new sphere every cycle. Fields: centre_x/y/z (signed fixed point) and
//   sphere_radius (unsigned fixed point).
// Output: done pulses for one cycle with visible valid in the same cycle;
//   results come out in input order.
//   The receiver cannot stall; every result is presented exactly once.
// Throughput: one sphere per clock. Latency is set by the multiply chain:
//   products of centre with near/edge values, sum, split multiply by the
//   inverse plane length, partial-product add, threshold compare.
// Configuration: cfg_wr_en / cfg_addr / cfg_wdata write one frustum register
//   per cycle, only while no transaction is in flight (user rule, unchecked).
// Reset: rst_n clears the pipeline valid bits and loads a unit frustum
//   (near 1.0, far 100.0, edges at +/-1.0, inverse lengths 1/sqrt(2)).
module sphere_frustum_cull
    import sfc_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS,
    parameter int WORD_BITS = DEF_WORD_BITS
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [WORD_BITS-1:0] centre_x,
    input  logic signed [WORD_BITS-1:0] centre_y,
    input  logic signed [WORD_BITS-1:0] centre_z,
    input  logic        [WORD_BITS-2:0] sphere_radius,
    output logic                        done,
    output logic                        visible,
    input  logic                        cfg_wr_en,
    input  logic        [CFG_IDX_W-1:0] cfg_addr,
    input  logic        [WORD_BITS-1:0] cfg_wdata
);

    localparam int W      = WORD_BITS;
    localparam int PW     = 2 * W;
    localparam int PROD_W = 3 * W - 1;
    localparam int THR_W  = W + 2 * FRAC_BITS;
    localparam int CMP_W  = (PROD_W > THR_W) ? PROD_W : THR_W;
    localparam int DW     = W + 2;

    localparam logic [W-2:0] ONE_RST  = (W-1)'(64'd1 << FRAC_BITS);
    localparam logic [W-2:0] FAR_RST  = (W-1)'(64'(FAR_RESET_UNITS) << FRAC_BITS);
    localparam logic [W-2:0] INV_RST  =
        (W-1)'((INV_SQRT2_Q30 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
    localparam logic [W-1:0] NEG_ONE  = W'(-(64'sd1 <<< FRAC_BITS));
    localparam logic [W-2:0] R_MAX    = '1;

    // frustum registers
    logic        [W-2:0] near_reg, far_reg, right_reg, top_reg;
    logic signed [W-1:0] left_reg, bottom_reg;
    logic        [W-2:0] inv_side_reg, inv_vert_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_reg     <= ONE_RST;
            far_reg      <= FAR_RST;
            left_reg     <= NEG_ONE;
            right_reg    <= ONE_RST;
            bottom_reg   <= NEG_ONE;
            top_reg      <= ONE_RST;
            inv_side_reg <= INV_RST;
            inv_vert_reg <= INV_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_NEAR:     near_reg     <= cfg_wdata[W-2:0];
                REG_FAR:      far_reg      <= cfg_wdata[W-2:0];
                REG_LEFT:     left_reg     <= cfg_wdata;
                REG_RIGHT:    right_reg    <= cfg_wdata[W-2:0];
                REG_BOTTOM:   bottom_reg   <= cfg_wdata;
                REG_TOP:      top_reg      <= cfg_wdata[W-2:0];
                REG_INV_SIDE: inv_side_reg <= cfg_wdata[W-2:0];
                REG_INV_VERT: inv_vert_reg <= cfg_wdata[W-2:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // valid chain
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, done_reg;
    logic s1_valid_next;

    assign s1_valid_next = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            done_reg     <= s4_valid_reg;
        end
    end

    // stage 1: centre products, depth test
    logic signed [W-1:0]  near_s;
    logic signed [W-1:0]  edge_val [LANES];
    logic signed [DW-1:0] cz_e, r_e, n_e, f_e;
    logic signed [PW-1:0] s1_nc_next [2];
    logic signed [PW-1:0] s1_ze_next [LANES];
    logic                 s1_depth_cull_next;

    logic signed [PW-1:0] s1_nc_reg [2];
    logic signed [PW-1:0] s1_ze_reg [LANES];
    logic                 s1_depth_cull_reg;
    logic        [W-2:0]  s1_r_reg;

    always_comb
    begin
        near_s      = signed'({1'b0, near_reg});
        edge_val[0] = left_reg;
        edge_val[1] = signed'({1'b0, right_reg});
        edge_val[2] = bottom_reg;
        edge_val[3] = signed'({1'b0, top_reg});
        s1_nc_next[0] = near_s * centre_x;
        s1_nc_next[1] = near_s * centre_y;
        for (int k = 0; k < LANES; k++)
        begin
            s1_ze_next[k] = centre_z * edge_val[k];
        end
        cz_e = signed'({{2{centre_z[W-1]}}, centre_z});
        r_e  = signed'({3'b000, sphere_radius});
        n_e  = signed'({3'b000, near_reg});
        f_e  = signed'({3'b000, far_reg});
        s1_depth_cull_next = ((r_e - cz_e) < n_e) || ((-cz_e - r_e) > f_e);
    end

    // stage 2: signed plane distances
    logic signed [PW-1:0] side_d [LANES];
    logic        [W-1:0]  s2_lo_next [LANES];
    logic        [W-2:0]  s2_hi_next [LANES];
    logic                 s2_pos_next [LANES];

    logic        [W-1:0]  s2_lo_reg [LANES];
    logic        [W-2:0]  s2_hi_reg [LANES];
    logic                 s2_pos_reg [LANES];
    logic                 s2_depth_cull_reg;
    logic        [W-2:0]  s2_r_reg;

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            if ((k & 1) == 0)
            begin
                side_d[k] = -s1_nc_reg[k / 2] - s1_ze_reg[k];
            end
            else
            begin
                side_d[k] = s1_nc_reg[k / 2] + s1_ze_reg[k];
            end
            s2_pos_next[k] = !side_d[k][PW-1] && (side_d[k] != '0);
            s2_lo_next[k]  = side_d[k][W-1:0];
            s2_hi_next[k]  = side_d[k][PW-2:W];
        end
    end

    // stage 3: split multiply by inverse plane length
    logic [W-2:0]  lane_inv [LANES];
    logic [PW-2:0] s3_pl_next [LANES];
    logic [PW-3:0] s3_ph_next [LANES];

    logic [PW-2:0] s3_pl_reg [LANES];
    logic [PW-3:0] s3_ph_reg [LANES];
    logic          s3_pos_reg [LANES];
    logic          s3_depth_cull_reg;
    logic [W-2:0]  s3_r_reg;

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            lane_inv[k]   = (k < 2) ? inv_side_reg : inv_vert_reg;
            s3_pl_next[k] = (PW-1)'(s2_lo_reg[k]) * (PW-1)'(lane_inv[k]);
            s3_ph_next[k] = (PW-2)'(s2_hi_reg[k]) * (PW-2)'(lane_inv[k]);
        end
    end

    // stage 4: partial-product add, radius threshold
    logic [PROD_W-1:0] s4_prod_next [LANES];
    logic [CMP_W-1:0]  s4_thr_next;
    logic              s4_r_ok_next;

    logic [PROD_W-1:0] s4_prod_reg [LANES];
    logic              s4_pos_reg [LANES];
    logic              s4_depth_cull_reg;
    logic [CMP_W-1:0]  s4_thr_reg;
    logic              s4_r_ok_reg;

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            s4_prod_next[k] = PROD_W'(s3_pl_reg[k])
                            + PROD_W'({s3_ph_reg[k], {W{1'b0}}});
        end
        s4_thr_next  = (CMP_W'(s3_r_reg) + CMP_W'(1)) << (2 * FRAC_BITS);
        s4_r_ok_next = (s3_r_reg != R_MAX);
    end

    // stage 5: compare, result
    logic side_cull;
    logic visible_next;
    logic visible_reg;

    always_comb
    begin
        side_cull = 1'b0;
        for (int k = 0; k < LANES; k++)
        begin
            if (s4_pos_reg[k] && (CMP_W'(s4_prod_reg[k]) >= s4_thr_reg))
            begin
                side_cull = 1'b1;
            end
        end
        visible_next = !(s4_depth_cull_reg || (s4_r_ok_reg && side_cull));
    end

    always_ff @(posedge clk)
    begin
        s1_nc_reg         <= s1_nc_next;
        s1_ze_reg         <= s1_ze_next;
        s1_depth_cull_reg <= s1_depth_cull_next;
        s1_r_reg          <= sphere_radius;

        s2_lo_reg         <= s2_lo_next;
        s2_hi_reg         <= s2_hi_next;
        s2_pos_reg        <= s2_pos_next;
        s2_depth_cull_reg <= s1_depth_cull_reg;
        s2_r_reg          <= s1_r_reg;

        s3_pl_reg         <= s3_pl_next;
        s3_ph_reg         <= s3_ph_next;
        s3_pos_reg        <= s2_pos_reg;
        s3_depth_cull_reg <= s2_depth_cull_reg;
        s3_r_reg          <= s2_r_reg;

        s4_prod_reg       <= s4_prod_next;
        s4_pos_reg        <= s3_pos_reg;
        s4_depth_cull_reg <= s3_depth_cull_reg;
        s4_thr_reg        <= s4_thr_next;
        s4_r_ok_reg       <= s4_r_ok_next;

        visible_reg       <= visible_next;
    end

    assign done    = done_reg;
    assign visible = visible_reg;

    // every accepted transaction yields a result
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##5 done)
        else $error("accepted transaction produced no result");

    // no result without an earlier accepted transaction
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 5))
        else $error("result without a transaction");

    // a depth-culled sphere is never reported visible
    a_depth_cull: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(s1_valid_reg && s1_depth_cull_reg, 4)) |-> !visible)
        else $error("depth-culled sphere reported visible");

endmodule

// File: verif/sphere_frustum_cull_tb.sv
`timescale 1ns / 1ps

module sphere_frustum_cull_tb;
    import sfc_pkg::*;

    localparam int FRAC = DEF_FRAC_BITS;
    localparam int WORD = DEF_WORD_BITS;
    localparam logic signed [127:0] SAT_MAX = (128'sd1 <<< (WORD - 1)) - 128'sd1;

    typedef struct {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic [30:0]        rad;
        int                 gap;
    } sphere_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] centre_x;
    logic signed [31:0] centre_y;
    logic signed [31:0] centre_z;
    logic [30:0]        sphere_radius;
    logic               done;
    logic               visible;
    logic               cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [31:0]        cfg_wdata;

    // frustum registers as the block should hold them
    logic [30:0]        fr_near, fr_far, fr_right, fr_top, fr_inv_side, fr_inv_vert;
    logic signed [31:0] fr_left, fr_bottom;

    sphere_t sphere_q[$];
    logic    vis_expected_q[$];
    int      n_issued;
    int      n_done;
    int      n_err;
    logic    took;
    int      gap_left;
    bit      gap_loaded;
    bit      burst;

    sphere_frustum_cull u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .centre_x      (centre_x),
        .centre_y      (centre_y),
        .centre_z      (centre_z),
        .sphere_radius (sphere_radius),
        .done          (done),
        .visible       (visible),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit plane_rejects(logic signed [95:0] plane_d, logic [30:0] inv,
                                         logic [30:0] rad);
        logic signed [127:0] scaled;
        scaled = (plane_d * $signed({97'b0, inv})) >>> (2 * FRAC);
        if (scaled > SAT_MAX)
            scaled = SAT_MAX;
        return scaled > $signed({97'b0, rad});
    endfunction

    function automatic logic sphere_in_frustum(logic signed [31:0] cx, logic signed [31:0] cy,
                                               logic signed [31:0] cz, logic [30:0] rad);
        logic signed [95:0] x, y, z, r, nr, fa, lf, rt, bt, tp, zc;
        x  = cx;
        y  = cy;
        z  = cz;
        r  = $signed({65'b0, rad});
        nr = $signed({65'b0, fr_near});
        fa = $signed({65'b0, fr_far});
        lf = fr_left;
        bt = fr_bottom;
        rt = $signed({65'b0, fr_right});
        tp = $signed({65'b0, fr_top});
        zc = -z;
        if (zc + r < nr || zc - r > fa)
            return 1'b0;
        if (plane_rejects(-(nr * x) - z * lf, fr_inv_side, rad))
            return 1'b0;
        if (plane_rejects(z * rt + nr * x, fr_inv_side, rad))
            return 1'b0;
        if (plane_rejects(-(nr * y) - z * bt, fr_inv_vert, rad))
            return 1'b0;
        if (plane_rejects(z * tp + nr * y, fr_inv_vert, rad))
            return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic signed [31:0] to_q(real v);
        if (v >= 2147483647.0)
            return 32'sh7FFFFFFF;
        if (v <= -2147483648.0)
            return 32'sh80000000;
        return $rtoi(v);
    endfunction

    function automatic logic [30:0] to_rad(real v);
        if (v < 0.0)
            v = -v;
        if (v >= 2147483647.0)
            return 31'h7FFFFFFF;
        return 31'($rtoi(v));
    endfunction

    function automatic logic [31:0] inv_len(real a, real b);
        real d;
        d = $sqrt(a * a + b * b);
        if (d < 2.0)
            return 32'h7FFFFFFF;
        return {1'b0, to_rad(4294967296.0 / d)};
    endfunction

    // driver
    always @(negedge clk)
    begin
        bit      go;
        sphere_t s;
        go = 1'b0;
        if (rst_n && (!start || took))
        begin
            if (sphere_q.size() > 0)
            begin
                if (!gap_loaded)
                begin
                    gap_left   = sphere_q[0].gap;
                    gap_loaded = 1'b1;
                end
                if (gap_left > 0)
                    gap_left--;
                else
                begin
                    s = sphere_q.pop_front();
                    gap_loaded = 1'b0;
                    go = 1'b1;
                    centre_x      <= s.cx;
                    centre_y      <= s.cy;
                    centre_z      <= s.cz;
                    sphere_radius <= s.rad;
                end
            end
            start <= go;
        end
    end

    // monitor and checker
    always @(posedge clk)
    begin
        logic e;
        if (!rst_n)
            took <= 1'b0;
        else
        begin
            took <= start && !busy;
            if (start && !busy)
                vis_expected_q.push_back(
                    sphere_in_frustum(centre_x, centre_y, centre_z, sphere_radius));
            if (done)
            begin
                n_done <= n_done + 1;
                if (vis_expected_q.size() == 0)
                begin
                    $error("visible: unexpected transaction, got %0b", visible);
                    n_err++;
                end
                else
                begin
                    e = vis_expected_q.pop_front();
                    if (visible !== e)
                    begin
                        $error("visible: expected %0b, actual %0b", e, visible);
                        n_err++;
                    end
                end
            end
        end
    end

    task automatic push_sphere(logic signed [31:0] cx, logic signed [31:0] cy,
                               logic signed [31:0] cz, logic [30:0] rad);
        sphere_t s;
        s.cx  = cx;
        s.cy  = cy;
        s.cz  = cz;
        s.rad = rad;
        s.gap = burst ? 0 : $urandom_range(0, 17);
        sphere_q.push_back(s);
        n_issued++;
    endtask

    task automatic wait_drained();
        while (n_done < n_issued)
            @(negedge clk);
    endtask

    task automatic set_frustum(logic [31:0] n, logic [31:0] f, logic [31:0] l,
                               logic [31:0] r, logic [31:0] b, logic [31:0] t,
                               logic [31:0] is, logic [31:0] iv);
        logic [31:0] w [8];
        logic [CFG_IDX_W-1:0] idx;
        w = '{n, f, l, r, b, t, is, iv};
        for (int i = 0; i < 8; i++)
        begin
            idx = i[CFG_IDX_W-1:0];
            cfg_wr_en <= 1'b1;
            cfg_addr  <= idx;
            cfg_wdata <= w[i];
            case (idx)
                REG_NEAR:     fr_near     = w[i][30:0];
                REG_FAR:      fr_far      = w[i][30:0];
                REG_LEFT:     fr_left     = w[i];
                REG_RIGHT:    fr_right    = w[i][30:0];
                REG_BOTTOM:   fr_bottom   = w[i];
                REG_TOP:      fr_top      = w[i][30:0];
                REG_INV_SIDE: fr_inv_side = w[i][30:0];
                REG_INV_VERT: fr_inv_vert = w[i][30:0];
                default: ;
            endcase
            @(negedge clk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // mostly spheres placed around the frustum at the current settings,
    // some sitting on the near/far planes, some pure noise
    task automatic run_phase(int n);
        real nr, fa, zc, sc, fx, fy, rr, u;
        int  kind;
        for (int k = 0; k < n; k++)
        begin
            if (k % 64 == 0)
                burst = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 19);
            nr = fr_near;
            fa = fr_far;
            u  = $urandom_range(0, 1000) / 1000.0;
            rr = 0.5 * (nr + fa) * u * u * u;
            if ($urandom_range(0, 9) == 0)
                rr = 0.0;
            if (kind < 3)
                push_sphere($urandom, $urandom, $urandom, 31'($urandom));
            else if (kind < 5)
            begin
                rr = $urandom_range(0, 1 << 20);
                zc = ($urandom_range(0, 1) ? nr - rr : fa + rr)
                     + $itor($urandom_range(0, 2)) - 1.0;
                push_sphere($urandom_range(0, 1) ? 32'sd0 : to_q($urandom_range(0, 255)),
                            32'sd0, to_q(-zc), to_rad(rr));
            end
            else
            begin
                zc = nr + ($urandom_range(0, 1400) / 1000.0 - 0.2) * (fa - nr);
                sc = (nr > 0.0) ? zc / nr : 1.0;
                fx = fr_left + ($urandom_range(0, 1400) / 1000.0 - 0.2)
                     * (real'(fr_right) - real'(fr_left));
                fy = fr_bottom + ($urandom_range(0, 1400) / 1000.0 - 0.2)
                     * (real'(fr_top) - real'(fr_bottom));
                push_sphere(to_q(fx * sc), to_q(fy * sc), to_q(-zc), to_rad(rr));
            end
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        start         = 1'b0;
        centre_x      = '0;
        centre_y      = '0;
        centre_z      = '0;
        sphere_radius = '0;
        cfg_wr_en     = 1'b0;
        cfg_addr      = '0;
        cfg_wdata     = '0;
        n_issued      = 0;
        n_done        = 0;
        n_err         = 0;
        gap_left      = 0;
        gap_loaded    = 1'b0;
        burst         = 1'b0;
        fr_near       = 31'd65536;
        fr_far        = 31'd6553600;
        fr_left       = -32'sd65536;
        fr_right      = 31'd65536;
        fr_bottom     = -32'sd65536;
        fr_top        = 31'd65536;
        fr_inv_side   = 31'd46341;
        fr_inv_vert   = 31'd46341;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // reset frustum: depth planes, exact plane contact, radius vs scaled distance
        push_sphere(0, 0, -32'sd65536, 0);
        push_sphere(0, 0, -32'sd65535, 0);
        push_sphere(0, 0, -32'sd6553600, 0);
        push_sphere(0, 0, -32'sd6553601, 0);
        push_sphere(0, 0, 0, 31'd65536);
        push_sphere(0, 0, -32'sd6619136, 31'd65536);
        push_sphere(0, 0, -32'sd6619137, 31'd65536);
        push_sphere(32'sd131072, 0, -32'sd131072, 0);
        push_sphere(32'sd196608, 0, -32'sd131072, 31'd46340);
        push_sphere(32'sd196608, 0, -32'sd131072, 31'd46341);
        push_sphere(-32'sd196608, 0, -32'sd131072, 31'd46340);
        push_sphere(-32'sd196608, 0, -32'sd131072, 31'd46341);
        push_sphere(0, 32'sd196608, -32'sd131072, 31'd46340);
        push_sphere(0, 32'sd196608, -32'sd131072, 31'd46341);
        push_sphere(0, -32'sd196608, -32'sd131072, 31'd46340);
        push_sphere(0, -32'sd196608, -32'sd131072, 31'd46341);
        push_sphere(32'sh7FFFFFFF, 0, -32'sd131072, 31'h7FFFFFFF);
        push_sphere(32'sh7FFFFFFF, 0, -32'sd131072, 31'h7FFFFFFE);
        push_sphere(32'sh80000000, 32'sh80000000, 32'sh80000000, 0);
        push_sphere(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 31'h7FFFFFFF);
        push_sphere(0, 0, 32'sh80000000, 31'h7FFFFFFF);
        push_sphere(0, 0, 0, 31'h7FFFFFFF);
        push_sphere(0, 0, -32'sd655360, 31'd65536);
        wait_drained();

        set_frustum(32'd32768, 32'd16384000, -32'sd52429, 32'd78643, -32'sd39322, 32'd58982,
                    inv_len(32768.0, -52429.0), inv_len(32768.0, -39322.0));
        run_phase(250);
        set_frustum(32'd131072, 32'd1310720, -32'sd16384, 32'd16384, -32'sd8192, 32'd24576,
                    inv_len(131072.0, -16384.0), inv_len(131072.0, -8192.0));
        run_phase(250);
        set_frustum(32'hFFFFFFFF, 32'hFFFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                    32'h80000000, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF);
        run_phase(150);
        set_frustum(0, 0, 0, 0, 0, 0, 0, 0);
        run_phase(100);
        for (int p = 0; p < 5; p++)
        begin
            set_frustum($urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom, $urandom);
            run_phase(100);
        end
        set_frustum(32'd65536, 32'd6553600, -32'sd65536, 32'd65536,
                    -32'sd65536, 32'd65536, 32'd46341, 32'd46341);
        run_phase(300);

        repeat (10) @(posedge clk);
        if (vis_expected_q.size() != 0)
        begin
            $error("visible: %0d expected transactions never arrived", vis_expected_q.size());
            n_err++;
        end
        if (n_err == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
